### hw/rtl/oaht_pkg.sv
package oaht_pkg;

    localparam logic [31:0] HASH_MUL = 32'h811C9DC5;
    localparam int REM_W = 9;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [2:0] RS_FOUND    = 3'd0;
    localparam logic [2:0] RS_MISS     = 3'd1;
    localparam logic [2:0] RS_UPDATED  = 3'd2;
    localparam logic [2:0] RS_INSERTED = 3'd3;
    localparam logic [2:0] RS_FULL     = 3'd4;

    localparam logic [1:0] SL_EMPTY = 2'd0;
    localparam logic [1:0] SL_USED  = 2'd1;
    localparam logic [1:0] SL_TOMB  = 2'd2;

    typedef struct packed {
        logic clr;
        logic load;
        logic hash;
        logic modr;
        logic chk;
        logic wr;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic hash_last;
        logic mod_last;
        logic chk_done;
        logic out_free;
    } t_dp_sts;

    // four restoring remainder steps, remainder always below the divisor
    function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] rem,
                                                  input logic [3:0] nib,
                                                  input logic [REM_W-1:0] d);
        logic [REM_W-1:0] r;
        r = rem;
        for (int k = 3; k >= 0; k--) begin
            r = {r[REM_W-2:0], nib[k]};
            if (r >= d) begin
                r = r - d;
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/oaht_ram.sv
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hw/rtl/oaht_ctrl.sv
module oaht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  oaht_pkg::t_dp_sts i_sts,
    output oaht_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_HASH = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_WR   = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                if (i_sts.hash_last) n_state = S_MOD;
            end
            S_MOD: begin
                o_cmd.modr = 1'b1;
                if (i_sts.mod_last) n_state = S_RD;
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.chk_done ? S_WR : S_RD;
            end
            S_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/oaht_dp.sv
module oaht_dp #(
    parameter int BUCKET_COUNT     = 16,
    parameter int SLOTS_PER_BUCKET = 16,
    parameter int KEY_BYTES        = 8,
    parameter int VALUE_BITS       = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  oaht_pkg::t_dp_cmd i_cmd,
    output oaht_pkg::t_dp_sts o_sts,
    input  logic [1:0]        i_command,
    input  logic [63:0]       i_key_bytes,
    input  logic [3:0]        i_key_length,
    input  logic [63:0]       i_new_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_status,
    output logic [63:0]       o_read_value
);

    localparam int RW    = oaht_pkg::REM_W;
    localparam int TSIZE = BUCKET_COUNT * SLOTS_PER_BUCKET;
    localparam int AW    = $clog2(TSIZE);
    localparam int WW    = 2 + 64 + 4 + VALUE_BITS;
    localparam logic [RW-1:0] DIV_B  = RW'(BUCKET_COUNT);
    localparam logic [RW-1:0] DIV_S  = RW'(SLOTS_PER_BUCKET);
    localparam logic [RW-1:0] S_LAST = RW'(SLOTS_PER_BUCKET - 1);
    localparam logic [AW-1:0] A_LAST = AW'(TSIZE - 1);
    localparam logic [3:0]    KB     = 4'(KEY_BYTES);

    logic [1:0]            r_cmd;
    logic [63:0]           r_raw;
    logic [3:0]            r_limit;
    logic [VALUE_BITS-1:0] r_val;
    logic [63:0]           r_key;
    logic [3:0]            r_len;
    logic [3:0]            r_bi;
    logic [31:0]           r_h;
    logic [31:0]           r_hq;
    logic [2:0]            r_mcnt;
    logic [RW-1:0]         r_rb, r_rs, r_off, r_j;
    logic                  r_hit, r_free_v;
    logic [AW-1:0]         r_hit_addr, r_free_addr, r_clr;
    logic [VALUE_BITS-1:0] r_hval;
    logic                  r_ovalid;
    logic [2:0]            r_status;
    logic [VALUE_BITS-1:0] r_rvalue;

    logic [7:0]            w_byte;
    logic [31:0]           w_prod;
    logic [RW-1:0]         n_rb, n_rs;
    logic [AW-1:0]         w_addr;
    logic [WW-1:0]         w_rdata, w_wdata;
    logic [AW-1:0]         w_waddr;
    logic                  w_we;
    logic [1:0]            w_st;
    logic                  w_used, w_match, w_stop;
    logic [2:0]            w_res;
    logic [VALUE_BITS-1:0] w_rv;
    logic                  w_put;
    logic [1:0]            w_put_st;
    logic [AW-1:0]         w_put_addr;

    assign w_byte = r_raw[{r_bi[2:0], 3'b000} +: 8];
    assign w_prod = r_h * oaht_pkg::HASH_MUL;
    assign n_rb   = oaht_pkg::rem_step(r_rb, r_hq[31:28], DIV_B);
    assign n_rs   = oaht_pkg::rem_step(r_rs, r_hq[31:28], DIV_S);
    assign w_addr = AW'(32'(r_rb) * 32'(SLOTS_PER_BUCKET) + 32'(r_off));

    assign w_st    = w_rdata[WW-1 -: 2];
    assign w_used  = (w_st == oaht_pkg::SL_USED);
    assign w_match = w_used && (w_rdata[WW-3 -: 64] == r_key)
                     && (w_rdata[VALUE_BITS +: 4] == r_len);
    assign w_stop  = !w_used && (w_st != oaht_pkg::SL_TOMB);

    assign o_sts.clr_last  = (r_clr == A_LAST);
    assign o_sts.hash_last = (r_bi >= r_limit) || (w_byte == 8'd0);
    assign o_sts.mod_last  = (r_mcnt == 3'd7);
    assign o_sts.chk_done  = w_match || w_stop || (r_j == S_LAST);
    assign o_sts.out_free  = !r_ovalid || !i_stall;

    // result and table update for the finished probe
    always_comb begin
        w_res      = oaht_pkg::RS_MISS;
        w_rv       = '0;
        w_put      = 1'b0;
        w_put_st   = oaht_pkg::SL_USED;
        w_put_addr = r_hit_addr;
        unique case (r_cmd)
            oaht_pkg::OP_LOOKUP: begin
                if (r_hit) begin
                    w_res = oaht_pkg::RS_FOUND;
                    w_rv  = r_hval;
                end
            end
            oaht_pkg::OP_INSERT: begin
                if (r_hit) begin
                    w_res = oaht_pkg::RS_UPDATED;
                    w_put = 1'b1;
                end else if (r_free_v) begin
                    w_res      = oaht_pkg::RS_INSERTED;
                    w_put      = 1'b1;
                    w_put_addr = r_free_addr;
                end else begin
                    w_res = oaht_pkg::RS_FULL;
                end
            end
            oaht_pkg::OP_DELETE: begin
                if (r_hit) begin
                    w_res    = oaht_pkg::RS_FOUND;
                    w_put    = 1'b1;
                    w_put_st = oaht_pkg::SL_TOMB;
                end
            end
            default: w_res = oaht_pkg::RS_MISS;
        endcase
    end

    always_comb begin
        if (i_cmd.clr) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = {oaht_pkg::SL_EMPTY, {(WW-2){1'b0}}};
        end else begin
            w_we    = i_cmd.wr && w_put;
            w_waddr = w_put_addr;
            w_wdata = {w_put_st, r_key, r_len, r_val};
        end
    end

    oaht_ram #(.WIDTH(WW), .DEPTH(TSIZE)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.wr) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_raw   <= i_key_bytes;
            r_limit <= (i_key_length > KB) ? KB : i_key_length;
            r_val   <= i_new_value[VALUE_BITS-1:0];
            r_key   <= '0;
            r_len   <= '0;
            r_bi    <= '0;
            r_h     <= '0;
        end
        if (i_cmd.hash) begin
            if (o_sts.hash_last) begin
                r_hq   <= r_h;
                r_rb   <= '0;
                r_rs   <= '0;
                r_mcnt <= '0;
            end else begin
                r_h                          <= w_prod ^ {24'd0, w_byte};
                r_key[{r_bi[2:0], 3'b000} +: 8] <= w_byte;
                r_len                        <= r_len + 4'd1;
                r_bi                         <= r_bi + 4'd1;
            end
        end
        if (i_cmd.modr) begin
            r_rb   <= n_rb;
            r_rs   <= n_rs;
            r_hq   <= {r_hq[27:0], 4'd0};
            r_mcnt <= r_mcnt + 3'd1;
            if (o_sts.mod_last) begin
                r_off    <= n_rs;
                r_j      <= '0;
                r_hit    <= 1'b0;
                r_free_v <= 1'b0;
            end
        end
        if (i_cmd.chk) begin
            if (w_match) begin
                r_hit      <= 1'b1;
                r_hit_addr <= w_addr;
                r_hval     <= w_rdata[VALUE_BITS-1:0];
            end
            if (!w_used && !r_free_v) begin
                r_free_v    <= 1'b1;
                r_free_addr <= w_addr;
            end
            r_off <= (r_off == S_LAST) ? '0 : r_off + 1'b1;
            r_j   <= r_j + 1'b1;
        end
        if (i_cmd.wr) begin
            r_status <= w_res;
            r_rvalue <= w_rv;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_status;
    assign o_read_value = 64'(r_rvalue);

endmodule

### hw/rtl/open_addressing_hash_table_top.sv
// Each item is accepted, hashed over up to KEY_BYTES key bytes (one multiply each),
// reduced in 4-bit remainder steps, probed slot by slot (RAM read, then check) and
// written back. One item at a time; the write waits while the output is stalled.
// Reset (synchronous, active low) starts a clearing pass that marks all
// BUCKET_COUNT*SLOTS_PER_BUCKET slots empty; no item is taken until it finishes.
module open_addressing_hash_table_top #(
    parameter int BUCKET_COUNT     = 16,
    parameter int SLOTS_PER_BUCKET = 16,
    parameter int KEY_BYTES        = 8,
    parameter int VALUE_BITS       = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_key_bytes,
    input  logic [3:0]  i_key_length,
    input  logic [63:0] i_new_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [63:0] o_read_value
);

    oaht_pkg::t_dp_cmd w_cmd;
    oaht_pkg::t_dp_sts w_sts;

    oaht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    oaht_dp #(
        .BUCKET_COUNT     (BUCKET_COUNT),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
        .KEY_BYTES        (KEY_BYTES),
        .VALUE_BITS       (VALUE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_command    (i_command),
        .i_key_bytes  (i_key_bytes),
        .i_key_length (i_key_length),
        .i_new_value  (i_new_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_read_value (o_read_value)
    );

endmodule
